/* hw/rtl/bsc_pkg.sv */
// Shared types, constants and step tables for the six-step commutator.
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

    localparam int PERIOD_WIDTH = 16;
    localparam int STEPS_WIDTH  = 16;
    localparam int CFG_WIDTH    = (PERIOD_WIDTH > STEPS_WIDTH) ? PERIOD_WIDTH : STEPS_WIDTH;

    localparam logic [2:0] NUM_STEPS  = 3'd6;
    localparam logic [2:0] LAST_STEP  = 3'd5;

    localparam logic [PERIOD_WIDTH-1:0] RST_INITIAL_PERIOD = PERIOD_WIDTH'(7000);
    localparam logic [STEPS_WIDTH-1:0]  RST_STARTUP_STEPS  = STEPS_WIDTH'(1000);
    localparam logic [PERIOD_WIDTH-1:0] RST_FINAL_PERIOD   = PERIOD_WIDTH'(2790);

    typedef enum logic [1:0] {
        REG_INITIAL_PERIOD = 2'd0,
        REG_STARTUP_STEPS  = 2'd1,
        REG_FINAL_PERIOD   = 2'd2,
        REG_UNUSED         = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [2:0] coil_drive;
        logic [2:0] phase_enable;
        logic [2:0] driven_step;
        logic       closed_loop;
        logic       hall_fault;
    } result_t;

    function automatic logic [2:0] next_step(input logic [2:0] s);
        next_step = (s >= LAST_STEP) ? 3'd0 : 3'(s + 3'd1);
    endfunction

    function automatic logic [2:0] coil_of(input logic [2:0] s);
        case (s)
            3'd0, 3'd5: coil_of = 3'b001;
            3'd1, 3'd2: coil_of = 3'b100;
            3'd3, 3'd4: coil_of = 3'b010;
            default:    coil_of = 3'b000;
        endcase
    endfunction

    function automatic logic [2:0] enable_of(input logic [2:0] s);
        case (s)
            3'd0, 3'd3: enable_of = 3'b011;
            3'd1, 3'd4: enable_of = 3'b110;
            3'd2, 3'd5: enable_of = 3'b101;
            default:    enable_of = 3'b000;
        endcase
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/bsc_core.sv */
// Commutation state, configuration registers and per-item step logic.
`timescale 1ns / 1ps
`default_nettype none
module bsc_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [bsc_pkg::CFG_WIDTH-1:0] cfg_data,
    input  wire logic                       item_take,
    input  wire logic                       hall_a,
    input  wire logic                       hall_b,
    input  wire logic                       hall_c,
    output bsc_pkg::result_t                result
);

    logic [bsc_pkg::PERIOD_WIDTH-1:0] initial_period_reg;
    logic [bsc_pkg::STEPS_WIDTH-1:0]  startup_steps_reg;
    logic [bsc_pkg::PERIOD_WIDTH-1:0] final_period_reg;

    logic [2:0]                       step_index_reg, step_index_next;
    logic [bsc_pkg::PERIOD_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [bsc_pkg::PERIOD_WIDTH-1:0] current_period_reg, current_period_next;
    logic [bsc_pkg::STEPS_WIDTH-1:0]  steps_remaining_reg, steps_remaining_next;
    logic                             hall_mode_reg, hall_mode_next;
    logic                             tracking_reg, tracking_next;
    logic [1:0]                       tracked_sum_reg, tracked_sum_next;
    logic                             fault_seen_reg, fault_seen_next;

    logic [1:0]                       sum;
    logic [bsc_pkg::PERIOD_WIDTH:0]   tc;
    logic [2:0]                       drive;
    logic [2:0]                       hall_step;
    logic                             still_tracking;

    always_comb
    begin
        sum = 2'({1'b0, hall_a} + {1'b0, hall_b} + {1'b0, hall_c});
        tc = {1'b0, tick_count_reg} + {{bsc_pkg::PERIOD_WIDTH{1'b0}}, 1'b1};

        step_index_next      = step_index_reg;
        tick_count_next      = tick_count_reg;
        current_period_next  = current_period_reg;
        steps_remaining_next = steps_remaining_reg;
        tracking_next        = tracking_reg;
        tracked_sum_next     = tracked_sum_reg;
        fault_seen_next      = fault_seen_reg;
        hall_mode_next       = hall_mode_reg
                               | ((steps_remaining_reg == '0)
                                  && (current_period_reg <= final_period_reg));

        hall_step      = step_index_reg;
        still_tracking = tracking_reg;
        if (tracking_reg && (sum != tracked_sum_reg))
        begin
            hall_step      = bsc_pkg::next_step(step_index_reg);
            still_tracking = 1'b0;
        end

        if (!hall_mode_next)
        begin
            if (tc >= {1'b0, current_period_reg})
            begin
                step_index_next = bsc_pkg::next_step(step_index_reg);
                tick_count_next = '0;
                if (steps_remaining_reg != '0)
                    steps_remaining_next = steps_remaining_reg
                                           - {{(bsc_pkg::STEPS_WIDTH-1){1'b0}}, 1'b1};
                else if (current_period_reg > final_period_reg)
                    current_period_next = current_period_reg
                                          - {{(bsc_pkg::PERIOD_WIDTH-1){1'b0}}, 1'b1};
            end
            else
            begin
                tick_count_next = tc[bsc_pkg::PERIOD_WIDTH-1:0];
            end
            drive = step_index_next;
        end
        else
        begin
            step_index_next = hall_step;
            if (still_tracking)
            begin
                drive = bsc_pkg::next_step(hall_step);
            end
            else if ((sum == 2'd1) || (sum == 2'd2))
            begin
                tracking_next    = 1'b1;
                tracked_sum_next = sum;
                drive            = bsc_pkg::next_step(hall_step);
            end
            else
            begin
                tracking_next   = 1'b0;
                fault_seen_next = 1'b1;
                drive           = hall_step;
            end
        end

        result.coil_drive   = bsc_pkg::coil_of(drive);
        result.phase_enable = bsc_pkg::enable_of(drive);
        result.driven_step  = drive;
        result.closed_loop  = hall_mode_next;
        result.hall_fault   = fault_seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_period_reg  <= bsc_pkg::RST_INITIAL_PERIOD;
            startup_steps_reg   <= bsc_pkg::RST_STARTUP_STEPS;
            final_period_reg    <= bsc_pkg::RST_FINAL_PERIOD;
            step_index_reg      <= '0;
            tick_count_reg      <= '0;
            current_period_reg  <= bsc_pkg::RST_INITIAL_PERIOD;
            steps_remaining_reg <= bsc_pkg::RST_STARTUP_STEPS;
            hall_mode_reg       <= 1'b0;
            tracking_reg        <= 1'b0;
            tracked_sum_reg     <= '0;
            fault_seen_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (bsc_pkg::cfg_index_t'(cfg_index))
                bsc_pkg::REG_INITIAL_PERIOD:
                begin
                    initial_period_reg <= cfg_data[bsc_pkg::PERIOD_WIDTH-1:0];
                    current_period_reg <= cfg_data[bsc_pkg::PERIOD_WIDTH-1:0];
                end
                bsc_pkg::REG_STARTUP_STEPS:
                begin
                    startup_steps_reg   <= cfg_data[bsc_pkg::STEPS_WIDTH-1:0];
                    steps_remaining_reg <= cfg_data[bsc_pkg::STEPS_WIDTH-1:0];
                end
                bsc_pkg::REG_FINAL_PERIOD:
                begin
                    final_period_reg <= cfg_data[bsc_pkg::PERIOD_WIDTH-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (item_take)
        begin
            step_index_reg      <= step_index_next;
            tick_count_reg      <= tick_count_next;
            current_period_reg  <= current_period_next;
            steps_remaining_reg <= steps_remaining_next;
            hall_mode_reg       <= hall_mode_next;
            tracking_reg        <= tracking_next;
            tracked_sum_reg     <= tracked_sum_next;
            fault_seen_reg      <= fault_seen_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_index_reg < bsc_pkg::NUM_STEPS)
        else $error("step index left the six-step range");

    a_hall_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        hall_mode_reg |=> hall_mode_reg)
        else $error("hall mode was left after entry");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault_seen_reg |=> fault_seen_reg)
        else $error("hall fault flag cleared");

    a_track_in_hall: assert property (@(posedge clk) disable iff (!rst_n)
        tracking_reg |-> (hall_mode_reg
                          && ((tracked_sum_reg == 2'd1) || (tracked_sum_reg == 2'd2))))
        else $error("tracking outside hall mode or with an invalid sum");
`endif

endmodule
`default_nettype wire

/* hw/rtl/bsc_out_fifo.sv */
// Two-entry result buffer that separates the step logic from the output stall.
`timescale 1ns / 1ps
`default_nettype none
module bsc_out_fifo (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire bsc_pkg::result_t push_data,
    output logic            full,
    output logic            out_valid,
    input  wire logic       out_stall,
    output bsc_pkg::result_t out_data
);

    bsc_pkg::result_t store_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        out_valid   = (count_reg != 2'd0);
        out_data    = store_reg[rd_ptr_reg];
        pop         = out_valid && !out_stall;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/bldc_six_step_commutator.sv */
// Top level of the six-step BLDC commutator with hall-sensor closed loop.
// Usage: each input item is one microsecond tick with the three hall levels
// on hall_a, hall_b and hall_c; it is taken when in_valid is high and
// in_stall is low. Every item yields exactly one result item on the output
// channel (coil_drive, phase_enable, driven_step, closed_loop, hall_fault),
// taken when out_valid is high and out_stall is low.
// Each taken item's result is formed combinationally and written into the
// result buffer. Throughput is one item per cycle while in_stall is low,
// set by the single pass of step logic between state registers and buffer.
// A two-entry result buffer lets the block take a new item while an earlier
// result waits; in_stall rises only when both entries are occupied, so a
// stalled receiver holds back at most two results.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; writes to the initial period or startup steps also reload
// the running counters. Write it only while the block is idle. On reset
// the default periods and step count load into settings and counters; the
// step, tick count, hall mode, fault flag and result buffer are cleared.
`timescale 1ns / 1ps
`default_nettype none
module bldc_six_step_commutator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          hall_a,
    input  wire logic                          hall_b,
    input  wire logic                          hall_c,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         coil_drive,
    output logic [2:0]                         phase_enable,
    output logic [2:0]                         driven_step,
    output logic                               closed_loop,
    output logic                               hall_fault,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [bsc_pkg::CFG_WIDTH-1:0] cfg_data
);

    bsc_pkg::result_t step_result;
    bsc_pkg::result_t out_data;
    logic             full;
    logic             item_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign item_take = in_valid && !full;

    bsc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_take (item_take),
        .hall_a    (hall_a),
        .hall_b    (hall_b),
        .hall_c    (hall_c),
        .result    (step_result)
    );

    bsc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_take),
        .push_data (step_result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign coil_drive   = out_data.coil_drive;
    assign phase_enable = out_data.phase_enable;
    assign driven_step  = out_data.driven_step;
    assign closed_loop  = out_data.closed_loop;
    assign hall_fault   = out_data.hall_fault;

endmodule
`default_nettype wire
